/* src/imu_window_resampler_defines.svh */
// Assertion macros for the IMU window resampler checker.
// Needs clock and reset in the scope where a macro is used.
`ifndef IMU_WINDOW_RESAMPLER_DEFINES_SVH
`define IMU_WINDOW_RESAMPLER_DEFINES_SVH

// Same-cycle implication.
`define IWR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IWR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/iwr_pkg.sv */
// Shared constants and types of the IMU window resampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iwr_pkg;
   localparam int TIME_BITS_DEF        = 48;
   localparam int SAMPLE_BITS_DEF      = 16;
   localparam int LAMBDA_FRAC_BITS_DEF = 16;
   localparam int AXES                 = 6;
   localparam int CSR_INDEX_BITS       = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_END   = 2'd1;

   // Interpolation operand pairs: (prev, cur) or (prev_prev, prev).
   typedef enum logic {
      PAIR_PREV_CUR  = 1'b0,
      PAIR_PPREV_PREV = 1'b1
   } pair_sel_type;

   typedef struct packed {
      logic is_first;
      logic is_final;
   } item_ctl_type;
endpackage
`default_nettype wire

/* src/iwr_front.sv */
// Input side: accepts items, unpacks fields and flags into a two-entry queue.
// Depends on iwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iwr_front #(
   parameter int TIME_BITS   = iwr_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = iwr_pkg::SAMPLE_BITS_DEF,
   parameter int DATA_BITS   = 144
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [DATA_BITS-1:0]              req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tuser,
   output logic                                   head_valid,
   output logic [TIME_BITS-1:0]                   head_time,
   output logic [iwr_pkg::AXES*SAMPLE_BITS-1:0]   head_axes,
   output iwr_pkg::item_ctl_type                  head_ctl,
   input  wire logic                              head_pop
);
   localparam int AXW = iwr_pkg::AXES * SAMPLE_BITS;
   localparam int EW  = TIME_BITS + AXW + 2;

   logic [EW-1:0] entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   logic [EW-1:0] head;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);
   assign head_time  = head[TIME_BITS-1:0];
   assign head_axes  = head[TIME_BITS +: AXW];
   assign head_ctl   = head[EW-1 -: 2];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {req_tuser, req_tlast, req_tdata[TIME_BITS +: AXW],
                                 req_tdata[TIME_BITS-1:0]};
      end
   end
endmodule
`default_nettype wire

/* src/iwr_interp.sv */
// Linear interpolation unit: bit-serial lambda divide, then each axis
// in a multiply and an add state on one multiplier. Depends on iwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iwr_interp #(
   parameter int TIME_BITS        = iwr_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS      = iwr_pkg::SAMPLE_BITS_DEF,
   parameter int LAMBDA_FRAC_BITS = iwr_pkg::LAMBDA_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                go,
   input  wire logic [TIME_BITS-1:0]                a_time,
   input  wire logic [iwr_pkg::AXES*SAMPLE_BITS-1:0] a_axes,
   input  wire logic [TIME_BITS-1:0]                b_time,
   input  wire logic [iwr_pkg::AXES*SAMPLE_BITS-1:0] b_axes,
   input  wire logic [TIME_BITS-1:0]                at_time,
   output logic                                     fin,
   output logic [TIME_BITS-1:0]                     res_time,
   output logic [iwr_pkg::AXES*SAMPLE_BITS-1:0]     res_axes
);
   localparam int AX  = iwr_pkg::AXES;
   localparam int SB  = SAMPLE_BITS;
   localparam int FB  = LAMBDA_FRAC_BITS;
   localparam int PW  = SB + FB + 2;
   localparam int CW  = $clog2(FB + 1);
   localparam int IW  = $clog2(AX);
   localparam int QW  = PW + 1 - FB;

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_DIV  = 4'b0010,
      U_MUL  = 4'b0100,
      U_ADD  = 4'b1000
   } unit_state_type;

   unit_state_type        state_ff, state_in;
   logic [AX*SB-1:0]      a_ax_ff, a_ax_in, b_ax_ff, b_ax_in, res_ff, res_in;
   logic [TIME_BITS-1:0]  t_ff, t_in, den_ff, den_in, rem_ff, rem_in;
   logic [FB:0]           lam_ff, lam_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic                  neg_ff, neg_in, fin_ff, fin_in;

   logic [TIME_BITS-1:0]  num, den;
   logic [TIME_BITS:0]    rem2;
   logic signed [SB:0]    av, bv, diff;
   logic [SB:0]           mag;
   logic [PW:0]           rsum;
   logic [QW-1:0]         q;
   logic signed [QW-1:0]  aext, axis_res;

   assign fin      = fin_ff;
   assign res_time = t_ff;
   assign res_axes = res_ff;

   always_comb begin
      state_in = state_ff;
      a_ax_in  = a_ax_ff;
      b_ax_in  = b_ax_ff;
      res_in   = res_ff;
      t_in     = t_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      lam_in   = lam_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      fin_in   = 1'b0;

      num  = at_time - a_time;
      den  = b_time - a_time;
      rem2 = {rem_ff, 1'b0};
      av   = {a_ax_ff[idx_ff*SB + SB - 1], a_ax_ff[idx_ff*SB +: SB]};
      bv   = {b_ax_ff[idx_ff*SB + SB - 1], b_ax_ff[idx_ff*SB +: SB]};
      diff = bv - av;
      mag  = diff[SB] ? (SB+1)'(-diff) : diff;
      rsum = {1'b0, prod_ff} + ((PW+1)'(1) << (FB - 1));
      q    = rsum[PW:FB];
      aext = QW'(av);
      axis_res = neg_ff ? aext - signed'(q) : aext + signed'(q);

      case (state_ff)
         U_IDLE: begin
            if (go) begin
               a_ax_in = a_axes;
               b_ax_in = b_axes;
               t_in    = at_time;
               den_in  = den;
               rem_in  = num;
               lam_in  = '0;
               idx_in  = '0;
               cnt_in  = CW'(FB);
               if (at_time <= a_time) begin
                  state_in = U_MUL;
               end else if (den == '0 || num >= den) begin
                  lam_in   = (FB+1)'(1) << FB;
                  state_in = U_MUL;
               end else begin
                  state_in = U_DIV;
               end
            end
         end
         U_DIV: begin
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = TIME_BITS'(rem2 - {1'b0, den_ff});
               lam_in = {lam_ff[FB-1:0], 1'b1};
            end else begin
               rem_in = rem2[TIME_BITS-1:0];
               lam_in = {lam_ff[FB-1:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            prod_in  = PW'(mag) * PW'(lam_ff);
            neg_in   = diff[SB];
            state_in = U_ADD;
         end
         U_ADD: begin
            res_in[idx_ff*SB +: SB] = axis_res[SB-1:0];
            if (idx_ff == IW'(AX - 1)) begin
               fin_in   = 1'b1;
               state_in = U_IDLE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = U_MUL;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ax_ff <= a_ax_in;
      b_ax_ff <= b_ax_in;
      res_ff  <= res_in;
      t_ff    <= t_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      lam_ff  <= lam_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end
endmodule
`default_nettype wire

/* src/iwr_back.sv */
// Window sequencer: selects, interpolates through iwr_interp, holds one item
// back and drives the result register. Depends on iwr_pkg, iwr_interp.
`timescale 1ns / 1ps
`default_nettype none
module iwr_back #(
   parameter int TIME_BITS        = iwr_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS      = iwr_pkg::SAMPLE_BITS_DEF,
   parameter int LAMBDA_FRAC_BITS = iwr_pkg::LAMBDA_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [TIME_BITS-1:0]                 window_start,
   input  wire logic [TIME_BITS-1:0]                 window_end,
   input  wire logic                                 head_valid,
   input  wire logic [TIME_BITS-1:0]                 head_time,
   input  wire logic [iwr_pkg::AXES*SAMPLE_BITS-1:0] head_axes,
   input  wire iwr_pkg::item_ctl_type                head_ctl,
   output logic                                      head_pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [TIME_BITS-1:0]                      rsp_time,
   output logic [iwr_pkg::AXES*SAMPLE_BITS-1:0]      rsp_axes,
   output logic                                      rsp_last,
   output logic                                      rsp_short,
   output logic                                      rsp_empty
);
   localparam int AXW = iwr_pkg::AXES * SAMPLE_BITS;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_WAIT   = 6'b000100,
      S_PUSH   = 6'b001000,
      S_CLOSE  = 6'b010000,
      S_DONE   = 6'b100000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic [TIME_BITS-1:0] prev_time_ff, prev_time_in, pp_time_ff, pp_time_in;
   logic [TIME_BITS-1:0] pend_time_ff, pend_time_in, r_time_ff, r_time_in;
   logic [AXW-1:0]       prev_axes_ff, prev_axes_in, pp_axes_ff, pp_axes_in;
   logic [AXW-1:0]       pend_axes_ff, pend_axes_in, r_axes_ff, r_axes_in;
   logic                 pz_ff, pz_in, have_ff, have_in, done_ff, done_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 second_ff, second_in, close_ff, close_in, upd_ff, upd_in;
   logic                 out_valid_ff, out_valid_in;
   logic [TIME_BITS-1:0] out_time_ff, out_time_in;
   logic [AXW-1:0]       out_axes_ff, out_axes_in;
   logic                 out_last_ff, out_last_in, out_short_ff, out_short_in;
   logic                 out_empty_ff, out_empty_in;

   logic                  go, ip_fin, out_free, drop_pend;
   iwr_pkg::pair_sel_type go_sel;
   logic [TIME_BITS-1:0]  go_time, ip_a_time, ip_b_time, ip_time;
   logic [AXW-1:0]        ip_a_axes, ip_b_axes, ip_axes;

   assign rsp_valid = out_valid_ff;
   assign rsp_time  = out_time_ff;
   assign rsp_axes  = out_axes_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_short = out_short_ff;
   assign rsp_empty = out_empty_ff;
   assign out_free  = !out_valid_ff || rsp_ready;
   // held item goes out only if the new one has another timestamp
   assign drop_pend = pend_valid_ff && (pend_time_ff != r_time_ff);

   always_comb begin
      if (go_sel == iwr_pkg::PAIR_PPREV_PREV) begin
         ip_a_time = pp_time_ff;   ip_a_axes = pp_axes_ff;
         ip_b_time = prev_time_ff; ip_b_axes = prev_axes_ff;
      end else begin
         ip_a_time = prev_time_ff; ip_a_axes = prev_axes_ff;
         ip_b_time = head_time;    ip_b_axes = head_axes;
      end
   end

   iwr_interp #(
      .TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS),
      .LAMBDA_FRAC_BITS(LAMBDA_FRAC_BITS)
   ) u_interp (
      .clock(clock), .reset(reset), .go(go),
      .a_time(ip_a_time), .a_axes(ip_a_axes),
      .b_time(ip_b_time), .b_axes(ip_b_axes),
      .at_time(go_time), .fin(ip_fin), .res_time(ip_time), .res_axes(ip_axes)
   );

   always_comb begin
      state_in      = state_ff;
      prev_time_in  = prev_time_ff;  prev_axes_in = prev_axes_ff;
      pp_time_in    = pp_time_ff;    pp_axes_in   = pp_axes_ff;
      pend_time_in  = pend_time_ff;  pend_axes_in = pend_axes_ff;
      r_time_in     = r_time_ff;     r_axes_in    = r_axes_ff;
      pz_in         = pz_ff;
      have_in       = have_ff;
      done_in       = done_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in        = cnt_ff;
      second_in     = second_ff;
      close_in      = close_ff;
      upd_in        = upd_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_time_in   = out_time_ff;   out_axes_in  = out_axes_ff;
      out_last_in   = out_last_ff;   out_short_in = out_short_ff;
      out_empty_in  = out_empty_ff;
      go            = 1'b0;
      go_sel        = iwr_pkg::PAIR_PREV_CUR;
      go_time       = window_end;
      head_pop      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               if (head_ctl.is_first) begin
                  have_in       = 1'b0;
                  pz_in         = 1'b1;
                  done_in       = 1'b0;
                  pend_valid_in = 1'b0;
                  cnt_in        = 2'd0;
               end
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            upd_in    = 1'b0;
            second_in = 1'b0;
            close_in  = head_ctl.is_final;
            if (done_ff) begin
               state_in = S_DONE;
            end else if (!have_ff) begin
               prev_time_in = head_time;
               prev_axes_in = head_axes;
               have_in      = 1'b1;
               state_in     = head_ctl.is_final ? S_CLOSE : S_DONE;
            end else if (head_time > window_start && prev_time_ff < window_start) begin
               // pair straddles the start
               go       = 1'b1;
               go_time  = window_start;
               upd_in   = 1'b1;
               state_in = S_WAIT;
            end else if (prev_time_ff >= window_start && head_time <= window_end) begin
               r_time_in = prev_time_ff;
               r_axes_in = prev_axes_ff;
               upd_in    = 1'b1;
               state_in  = S_PUSH;
            end else if (head_time > window_end) begin
               close_in = 1'b1;
               if (prev_time_ff > window_end && pz_ff) begin
                  state_in = S_CLOSE;
               end else if (prev_time_ff > window_end) begin
                  go       = 1'b1;
                  go_sel   = iwr_pkg::PAIR_PPREV_PREV;
                  state_in = S_WAIT;
               end else begin
                  r_time_in = prev_time_ff;
                  r_axes_in = prev_axes_ff;
                  second_in = (prev_time_ff != window_end);
                  state_in  = S_PUSH;
               end
            end else begin
               upd_in   = 1'b1;
               state_in = head_ctl.is_final ? S_CLOSE : S_DONE;
            end
         end
         S_WAIT: begin
            if (ip_fin) begin
               r_time_in = ip_time;
               r_axes_in = ip_axes;
               state_in  = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!drop_pend || out_free) begin
               if (drop_pend) begin
                  out_valid_in = 1'b1;
                  out_time_in  = pend_time_ff;
                  out_axes_in  = pend_axes_ff;
                  out_last_in  = 1'b0;
                  out_short_in = 1'b0;
                  out_empty_in = 1'b0;
                  if (cnt_ff != 2'd3) cnt_in = cnt_ff + 2'd1;
               end
               pend_time_in  = r_time_ff;
               pend_axes_in  = r_axes_ff;
               pend_valid_in = 1'b1;
               if (second_ff) begin
                  // end time not reached yet: interpolate on (prev, cur)
                  second_in = 1'b0;
                  go        = 1'b1;
                  state_in  = S_WAIT;
               end else begin
                  state_in = close_ff ? S_CLOSE : S_DONE;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  out_time_in  = pend_time_ff;
                  out_axes_in  = pend_axes_ff;
                  out_short_in = (cnt_ff == 2'd0);
                  out_empty_in = 1'b0;
                  if (cnt_ff != 2'd3) cnt_in = cnt_ff + 2'd1;
               end else begin
                  out_time_in  = '0;
                  out_axes_in  = '0;
                  out_short_in = 1'b1;
                  out_empty_in = 1'b1;
               end
               pend_valid_in = 1'b0;
               done_in       = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (upd_ff) begin
               pp_time_in   = prev_time_ff;
               pp_axes_in   = prev_axes_ff;
               prev_time_in = head_time;
               prev_axes_in = head_axes;
               pz_in        = 1'b0;
            end
            head_pop = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pz_ff         <= 1'b1;
         have_ff       <= 1'b0;
         done_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= 2'd0;
         second_ff     <= 1'b0;
         close_ff      <= 1'b0;
         upd_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pz_ff         <= pz_in;
         have_ff       <= have_in;
         done_ff       <= done_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         second_ff     <= second_in;
         close_ff      <= close_in;
         upd_ff        <= upd_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_time_ff <= prev_time_in;  prev_axes_ff <= prev_axes_in;
      pp_time_ff   <= pp_time_in;    pp_axes_ff   <= pp_axes_in;
      pend_time_ff <= pend_time_in;  pend_axes_ff <= pend_axes_in;
      r_time_ff    <= r_time_in;     r_axes_ff    <= r_axes_in;
      out_time_ff  <= out_time_in;   out_axes_ff  <= out_axes_in;
      out_last_ff  <= out_last_in;   out_short_ff <= out_short_in;
      out_empty_ff <= out_empty_in;
   end
endmodule
`default_nettype wire

/* src/imu_window_resampler.sv */
// IMU window resampler: selects and interpolates IMU samples for a time
// window. After the input queue, the sequencer takes an item through its
// idle, decode and done states, through its push state as well when the item
// is passed through or interpolated, and through its close state when the
// item closes the window. An interpolation runs the divider at one lambda
// bit per cycle, unless lambda is clamped, then each axis in turn on the
// shared multiplier, then hands the result back; an item needs at most one.
// The two-entry input queue keeps taking items while the sequencer works, and
// the result register lets the sequencer run on while a result waits; a second
// result stalls the sequencer until the first one is taken.
// Depends on iwr_pkg, iwr_front, iwr_interp, iwr_back.
`timescale 1ns / 1ps
`default_nettype none
module imu_window_resampler #(
   parameter int TIME_BITS        = iwr_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS      = iwr_pkg::SAMPLE_BITS_DEF,
   parameter int LAMBDA_FRAC_BITS = iwr_pkg::LAMBDA_FRAC_BITS_DEF,
   localparam int DATA_BITS = ((TIME_BITS + iwr_pkg::AXES * SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // sample_time, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  wire logic [DATA_BITS-1:0]               req_tdata,
   input  wire logic                               req_tlast,  // final_sample
   input  wire logic                               req_tuser,  // first_sample
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // out_time, out_accel_x/y/z, out_gyro_x/y/z
   output logic [DATA_BITS-1:0]                    rsp_tdata,
   output logic                                    rsp_tlast,  // last_of_window
   output logic [1:0]                              rsp_tuser,  // short_window, empty_window
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [iwr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [TIME_BITS-1:0]               csr_data
);
   localparam int AXW = iwr_pkg::AXES * SAMPLE_BITS;

   logic [TIME_BITS-1:0]  win_start_ff, win_end_ff;
   logic                  head_valid, head_pop, rsp_short, rsp_empty;
   logic [TIME_BITS-1:0]  head_time, rsp_time;
   logic [AXW-1:0]        head_axes, rsp_axes;
   iwr_pkg::item_ctl_type head_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '0;
      end else if (csr_valid) begin
         if (csr_index == iwr_pkg::CSR_WINDOW_START) win_start_ff <= csr_data;
         if (csr_index == iwr_pkg::CSR_WINDOW_END)   win_end_ff   <= csr_data;
      end
   end

   iwr_front #(
      .TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS), .DATA_BITS(DATA_BITS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .head_valid(head_valid), .head_time(head_time), .head_axes(head_axes),
      .head_ctl(head_ctl), .head_pop(head_pop)
   );

   iwr_back #(
      .TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS),
      .LAMBDA_FRAC_BITS(LAMBDA_FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .window_start(win_start_ff), .window_end(win_end_ff),
      .head_valid(head_valid), .head_time(head_time), .head_axes(head_axes),
      .head_ctl(head_ctl), .head_pop(head_pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_time(rsp_time), .rsp_axes(rsp_axes),
      .rsp_last(rsp_tlast), .rsp_short(rsp_short), .rsp_empty(rsp_empty)
   );

   assign rsp_tdata = DATA_BITS'({rsp_axes, rsp_time});
   assign rsp_tuser = {rsp_empty, rsp_short};
endmodule
`default_nettype wire

/* src/iwr_checker.sv */
// Port-level checks of the IMU window resampler, bound to the top level.
// Depends on iwr_pkg and imu_window_resampler_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_window_resampler_defines.svh"
module iwr_checker #(
   parameter int TIME_BITS   = iwr_pkg::TIME_BITS_DEF,
   parameter int SAMPLE_BITS = iwr_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_BITS = ((TIME_BITS + iwr_pkg::AXES * SAMPLE_BITS + 7) / 8) * 8
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [DATA_BITS-1:0] rsp_tdata,
   input wire logic                 rsp_tlast,
   input wire logic [1:0]           rsp_tuser
);
   `IWR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result item changed")
   `IWR_ASSERT_NOW(a_empty_form, rsp_tvalid && rsp_tuser[1], rsp_tlast && rsp_tuser[0] && (rsp_tdata == '0), "empty window item malformed")
   `IWR_ASSERT_NOW(a_short_last, rsp_tvalid && rsp_tuser[0], rsp_tlast, "short flag on a non-final item")
endmodule

bind imu_window_resampler iwr_checker #(
   .TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS)
) u_iwr_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);
`default_nettype wire
